[hdl/gbl_pkg.sv]
// shared types, constants and kernel weights for the 5x5 gaussian blur
package gbl_pkg;

  localparam int KSize    = 5;
  localparam int KRadius  = 2;
  localparam int Lines    = 4;
  localparam int NumTaps  = 25;
  localparam int TapW     = 5;
  localparam int RowW     = 3;
  localparam int ChanW    = 8;
  localparam int PixW     = 24;
  localparam int WidthW   = 11;
  localparam int HeightW  = 12;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 12;
  localparam int PosW     = 23;
  localparam int SumW     = 17;
  localparam int DivW     = 9;
  localparam int WeightW  = 6;
  localparam int QDepth   = 2;
  localparam int QPtrW    = 1;
  localparam int QLevelW  = 2;

  localparam logic [CfgIdxW-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam logic [WidthW-1:0]  WidthReset  = 11'd640;
  localparam logic [HeightW-1:0] HeightReset = 12'd480;

  typedef logic [PixW-1:0] pixel_t;

  // one window position to be filtered
  typedef struct packed {
    pixel_t [NumTaps-1:0] taps;
    logic [KSize-1:0]     row_ok;
    logic [KSize-1:0]     col_ok;
    logic                 eof;
  } job_t;

  typedef enum logic {
    F_IDLE,
    F_EXEC
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ACC,
    B_DIV,
    B_OUT
  } back_state_t;

  // one quadrant of the symmetric kernel
  localparam logic [WeightW-1:0] KQuad [3][3] = '{
    '{6'd1, 6'd4,  6'd7},
    '{6'd4, 6'd16, 6'd26},
    '{6'd7, 6'd26, 6'd41}
  };

  function automatic logic [WeightW-1:0] kernel_weight(input logic [RowW-1:0] j,
                                                       input logic [RowW-1:0] k);
    logic [RowW-1:0] jj;
    logic [RowW-1:0] kk;
    jj = (j > RowW'(KRadius)) ? RowW'(KSize - 1) - j : j;
    kk = (k > RowW'(KRadius)) ? RowW'(KSize - 1) - k : k;
    return KQuad[jj[1:0]][kk[1:0]];
  endfunction

endpackage

[hdl/gbl_if.sv]
// stream interfaces for incoming pixels and blurred results
interface gbl_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       drain;
  modport source (output valid, red, green, blue, drain, input ready);
  modport sink (input valid, red, green, blue, drain, output ready);
endinterface

interface gbl_blur_if;
  logic       valid;
  logic       ready;
  logic [7:0] blur_red;
  logic [7:0] blur_green;
  logic [7:0] blur_blue;
  logic       end_of_frame;
  modport source (output valid, blur_red, blur_green, blur_blue, end_of_frame, input ready);
  modport sink (input valid, blur_red, blur_green, blur_blue, end_of_frame, output ready);
endinterface

[hdl/gbl_front.sv]
// front end: takes pixels, keeps line stores and window, issues filter jobs
module gbl_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  gbl_pixel_if.sink                pixels,
  input  logic                     wr_en,
  input  logic [gbl_pkg::CfgIdxW-1:0]  wr_index,
  input  logic [gbl_pkg::CfgDataW-1:0] wr_data,
  output logic                     q_push,
  output gbl_pkg::job_t            q_job,
  input  logic                     q_ready
);
  import gbl_pkg::*;

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int WordW = Lines * PixW;
  localparam logic [WidthW+1:0] WLimit = (WidthW+2)'(MAX_WIDTH);

  front_state_t fstate, fstate_next;
  logic [WidthW-1:0]  frame_width;
  logic [HeightW-1:0] frame_height;
  logic [ColW-1:0]    col;
  logic [PosW-1:0]    pos_n;
  logic [WidthW-1:0]  out_x;
  logic [HeightW-1:0] out_y;
  pixel_t             pix_hold;
  logic [WordW-1:0]   line_mem [MAX_WIDTH];
  logic [WordW-1:0]   mem_rd;
  pixel_t [NumTaps-1:0] win;
  pixel_t [NumTaps-1:0] win_next;
  pixel_t [KSize-1:0]   colv;

  logic [PosW-1:0] total, lead;
  logic flushing, emit, eof, accept, proceed, take;
  logic [KSize-1:0] row_ok, col_ok;
  logic [WidthW-1:0]  wr_width;
  logic [HeightW-1:0] wr_height;

  assign total = PosW'({12'b0, frame_width} * {11'b0, frame_height});
  assign lead = (PosW'(frame_width) << 1) + PosW'(KRadius);
  assign flushing = pos_n >= total;
  assign emit = pos_n >= lead;
  assign eof = (out_x == frame_width - 1'b1) && (out_y == frame_height - 1'b1);
  assign accept = pixels.valid && pixels.ready;
  assign take = accept && (flushing || !pixels.drain);

  always_comb begin
    wr_width = wr_data[WidthW-1:0];
    if (wr_width == '0) wr_width = WidthW'(1);
    if ({2'b0, wr_width} > WLimit) wr_width = WLimit[WidthW-1:0];
    wr_height = wr_data[HeightW-1:0];
    if (wr_height == '0) wr_height = HeightW'(1);
  end

  // column of five: oldest row first, current pixel last
  always_comb begin
    for (int j = 0; j < Lines; j++) colv[j] = mem_rd[(Lines-1-j)*PixW +: PixW];
    colv[Lines] = pix_hold;
    for (int j = 0; j < KSize; j++) begin
      for (int k = 0; k < KSize; k++) begin
        win_next[j*KSize+k] = (k < KSize - 1) ? win[j*KSize+k+1] : colv[j];
      end
    end
  end

  always_comb begin
    logic [HeightW:0] yv;
    logic [WidthW:0]  xv;
    for (int j = 0; j < KSize; j++) begin
      yv = {1'b0, out_y} + (HeightW+1)'(j);
      row_ok[j] = (yv >= (HeightW+1)'(KRadius)) &&
                  (yv - (HeightW+1)'(KRadius) < {1'b0, frame_height});
      xv = {1'b0, out_x} + (WidthW+1)'(j);
      col_ok[j] = (xv >= (WidthW+1)'(KRadius)) &&
                  (xv - (WidthW+1)'(KRadius) < {1'b0, frame_width});
    end
  end

  always_comb begin
    fstate_next = fstate;
    case (fstate)
      F_IDLE: if (take) fstate_next = F_EXEC;
      F_EXEC: if (!emit || q_ready) fstate_next = F_IDLE;
      default: fstate_next = F_IDLE;
    endcase
  end

  always_comb begin
    pixels.ready = (fstate == F_IDLE);
    proceed = (fstate == F_EXEC) && (!emit || q_ready);
    q_push = (fstate == F_EXEC) && emit && q_ready;
    q_job.taps = win_next;
    q_job.row_ok = row_ok;
    q_job.col_ok = col_ok;
    q_job.eof = eof;
  end

  always_ff @(posedge clk) begin
    mem_rd <= line_mem[col];
    if (proceed) begin
      line_mem[col] <= {mem_rd[WordW-PixW-1:0], pix_hold};
      win <= win_next;
    end
    if (take) pix_hold <= flushing ? '0 : {pixels.blue, pixels.green, pixels.red};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate <= F_IDLE;
      frame_width <= WidthReset;
      frame_height <= HeightReset;
      col <= '0;
      pos_n <= '0;
      out_x <= '0;
      out_y <= '0;
    end else begin
      fstate <= fstate_next;
      if (wr_en && (wr_index == CFG_FRAME_WIDTH || wr_index == CFG_FRAME_HEIGHT)) begin
        if (wr_index == CFG_FRAME_WIDTH) frame_width <= wr_width;
        else frame_height <= wr_height;
        col <= '0;
        pos_n <= '0;
        out_x <= '0;
        out_y <= '0;
      end else if (proceed) begin
        if (emit && eof) begin
          col <= '0;
          pos_n <= '0;
          out_x <= '0;
          out_y <= '0;
        end else begin
          pos_n <= pos_n + 1'b1;
          if ({1'b0, col} + 1'b1 >= (ColW+1)'(frame_width)) col <= '0;
          else col <= col + 1'b1;
          if (emit) begin
            if (out_x == frame_width - 1'b1) begin
              out_x <= '0;
              out_y <= out_y + 1'b1;
            end else begin
              out_x <= out_x + 1'b1;
            end
          end
        end
      end
    end
  end

endmodule

[hdl/gbl_queue.sv]
// two-entry job queue between front and back ends
module gbl_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  gbl_pkg::job_t push_job,
  output logic          push_ready,
  output logic          pop_valid,
  output gbl_pkg::job_t pop_job,
  input  logic          pop,
  output logic [gbl_pkg::QLevelW-1:0] level
);
  import gbl_pkg::*;

  job_t slots [QDepth];
  logic [QPtrW-1:0] wr_ptr, rd_ptr;

  assign push_ready = level < QLevelW'(QDepth);
  assign pop_valid = level != '0;
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) level <= level + 1'b1;
      else if (pop && !push) level <= level - 1'b1;
    end
  end

endmodule

[hdl/gbl_back.sv]
// back end: weighted row sums, then an 8-step divider per channel on a shared divisor
module gbl_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  gbl_pkg::job_t q_job,
  output logic          q_pop,
  gbl_blur_if.source    blurred
);
  import gbl_pkg::*;

  back_state_t bstate, bstate_next;
  job_t job;
  logic [RowW-1:0] row;
  logic [RowW-1:0] step;
  logic [SumW-1:0] sum [3];
  logic [SumW-1:0] sum_acc [3];
  logic [SumW-1:0] sum_div [3];
  logic [ChanW-1:0] quo [3];
  logic [DivW-1:0] div_sum, div_acc, divisor;
  logic [SumW-1:0] dsh;
  logic out_load;

  always_comb begin
    logic [TapW-1:0] idx;
    logic [WeightW-1:0] wt;
    pixel_t p;
    for (int c = 0; c < 3; c++) sum_acc[c] = sum[c];
    div_acc = div_sum;
    for (int k = 0; k < KSize; k++) begin
      idx = TapW'(row) * TapW'(KSize) + TapW'(k);
      wt = kernel_weight(row, RowW'(k));
      p = job.taps[idx];
      if (job.row_ok[row] && job.col_ok[k]) begin
        for (int c = 0; c < 3; c++) begin
          sum_acc[c] = sum_acc[c] + SumW'(p[c*ChanW +: ChanW]) * SumW'(wt);
        end
        div_acc = div_acc + DivW'(wt);
      end
    end
  end

  // restoring division, one quotient bit per cycle
  assign divisor = (div_sum == '0) ? DivW'(1) : div_sum;
  assign dsh = SumW'(divisor) << step;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_div[c] = (sum[c] >= dsh) ? sum[c] - dsh : sum[c];
    end
  end

  always_comb begin
    bstate_next = bstate;
    case (bstate)
      B_IDLE: if (q_valid) bstate_next = B_ACC;
      B_ACC: if (row == RowW'(KSize - 1)) bstate_next = B_DIV;
      B_DIV: if (step == '0) bstate_next = B_OUT;
      B_OUT: if (!blurred.valid || blurred.ready) bstate_next = B_IDLE;
      default: bstate_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (bstate == B_IDLE) && q_valid;
    out_load = (bstate == B_OUT) && (!blurred.valid || blurred.ready);
  end

  always_ff @(posedge clk) begin
    case (bstate)
      B_IDLE: begin
        job <= q_job;
        row <= '0;
        div_sum <= '0;
        for (int c = 0; c < 3; c++) sum[c] <= '0;
      end
      B_ACC: begin
        row <= row + 1'b1;
        div_sum <= div_acc;
        for (int c = 0; c < 3; c++) sum[c] <= sum_acc[c];
        step <= RowW'(ChanW - 1);
      end
      B_DIV: begin
        step <= step - 1'b1;
        for (int c = 0; c < 3; c++) begin
          sum[c] <= sum_div[c];
          quo[c] <= {quo[c][ChanW-2:0], sum[c] >= dsh};
        end
      end
      default: ;
    endcase
    if (out_load) begin
      blurred.blur_red <= quo[0];
      blurred.blur_green <= quo[1];
      blurred.blur_blue <= quo[2];
      blurred.end_of_frame <= job.eof;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate <= B_IDLE;
      blurred.valid <= 1'b0;
    end else begin
      bstate <= bstate_next;
      if (out_load) blurred.valid <= 1'b1;
      else if (blurred.ready) blurred.valid <= 1'b0;
    end
  end

endmodule

[hdl/gaussian_blur_5x5_stream.sv]
// 5x5 gaussian blur over a raster pixel stream (kernel 1 4 7 4 1 ... sum 273).
// Edge taps outside the frame are dropped and the divisor shrinks to the
// weights that remain. Results lag two rows and two pixels; once a frame's
// pixels are in, each further request (drain or not) flushes one position.
// The front end takes one pixel at a time: a registered read of the line
// store (MAX_WIDTH words of four pixels), then an update of it and the
// window; it stalls while the job queue is full. Each result passes through
// the back end as a load, 5 row accumulations, 8 divider steps and an output
// load; a new job starts only once the last result is loaded. The line
// store is never cleared; only taps inside the frame are ever used.
module gaussian_blur_5x5_stream #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic clk,
  input  logic rst,
  gbl_pixel_if.sink  pixels,
  gbl_blur_if.source blurred,
  input  logic wr_en,
  input  logic [gbl_pkg::CfgIdxW-1:0]  wr_index,
  input  logic [gbl_pkg::CfgDataW-1:0] wr_data
);
  import gbl_pkg::*;

  logic q_push, q_ready, q_valid, q_pop;
  job_t push_job, pop_job;
  logic [QLevelW-1:0] q_level;

  gbl_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk(clk), .rst(rst), .pixels(pixels),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .q_push(q_push), .q_job(push_job), .q_ready(q_ready)
  );

  gbl_queue u_queue (
    .clk(clk), .rst(rst),
    .push(q_push), .push_job(push_job), .push_ready(q_ready),
    .pop_valid(q_valid), .pop_job(pop_job), .pop(q_pop), .level(q_level)
  );

  gbl_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_job(pop_job),
    .q_pop(q_pop), .blurred(blurred)
  );

`ifndef ASSERT_OFF
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    q_level <= QLevelW'(QDepth)) else $error("job queue overfilled");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> q_level < QLevelW'(QDepth)) else $error("push into full queue");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_level != '0) else $error("pop from empty queue");
  a_level_track: assert property (@(posedge clk) disable iff (rst)
    (q_push && !q_pop) |=> q_level == $past(q_level) + 1'b1)
    else $error("queue level lost a push");
`endif

endmodule
